/* src/ttd_pkg.sv */
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types and constants of the transient trigger detector: register
// indexes, fixed field widths, stage controls and the lane-to-merge flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttd_pkg;

  // fixed field widths
  localparam int TRIG_RATIO_W  = 17;
  localparam int REARM_RATIO_W = 16;
  localparam int LEVEL_W       = 24;
  localparam int ENV_FRAC      = 8;
  localparam int RATIO_FRAC    = 16;
  localparam int CFG_INDEX_W   = 3;

  // register reset values
  localparam int FAST_ATK_RESET  = 62757;
  localparam int FAST_REL_RESET  = 65400;
  localparam int SLOW_ATK_RESET  = 65508;
  localparam int SLOW_REL_RESET  = 65529;
  localparam int TRIG_RATIO_RESET  = 6554;
  localparam int REARM_RATIO_RESET = 4640;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FAST_ATK    = 3'd0,
    REG_FAST_REL    = 3'd1,
    REG_SLOW_ATK    = 3'd2,
    REG_SLOW_REL    = 3'd3,
    REG_TRIG_RATIO  = 3'd4,
    REG_REARM_RATIO = 3'd5
  } ttd_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_UPD,
    ST_RATIO,
    ST_DONE
  } ttd_state_t;

  // one strobe per processing step
  typedef struct packed {
    logic load;
    logic diff;
    logic mul;
    logic upd;
    logic ratio;
  } ttd_ctrl_t;

  // what one lane found in the current item
  typedef struct packed {
    logic trig;
    logic rearm;
  } ttd_hit_t;

endpackage

`default_nettype wire

/* src/transient_trigger_detector_unit.sv */
// ----------------------------------------------------------------------------
// transient_trigger_detector_unit
// Stereo transient trigger detector with fast and slow envelope followers.
//
// Input channel: one stereo frame per item (in_left_sample, in_right_sample),
// valid/ready. Result channel: one item per frame with the trigger pulse, the
// held flag and the integer part of all four envelopes, valid/ready.
// Configuration: write channel (cfg_index, cfg_wdata), always ready; write it
// only while no frame is in flight. Unknown indexes are ignored.
// An accepted frame runs the follower sequence of difference, multiply and
// update, then the ratio multiply and the final compare-and-merge step,
// which registers the result item. Both channels run in their own lane.
// A new frame is taken in the final step when the result register is free.
// Reset clears the envelopes, the held flag and the result valid, and loads
// the default coefficients and ratios. When the receiver stalls, the result
// item holds and the block waits in its final step; in_ready stays low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module transient_trigger_detector_unit #(
  parameter int SAMPLE_BITS  = 24,
  parameter int COEF_BITS    = 16,
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_right_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_trigger_pulse,
  output logic                                      out_trigger_held,
  output logic [ttd_pkg::LEVEL_W-1:0]               out_left_fast_level,
  output logic [ttd_pkg::LEVEL_W-1:0]               out_left_slow_level,
  output logic [ttd_pkg::LEVEL_W-1:0]               out_right_fast_level,
  output logic [ttd_pkg::LEVEL_W-1:0]               out_right_slow_level,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ttd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [((COEF_BITS > ttd_pkg::TRIG_RATIO_W) ?
                      COEF_BITS : ttd_pkg::TRIG_RATIO_W)-1:0] cfg_wdata
);
  import ttd_pkg::*;

  logic [COEF_BITS-1:0]     fast_atk_r, fast_rel_r, slow_atk_r, slow_rel_r;
  logic [TRIG_RATIO_W-1:0]  trig_ratio_r;
  logic [REARM_RATIO_W-1:0] rearm_ratio_r;

  ttd_state_t state_r, state_nxt;
  ttd_ctrl_t  ctrl;
  logic       out_free;
  logic       fire;
  logic       in_accept;

  logic signed [SAMPLE_BITS-1:0] samp [2];
  ttd_hit_t            hit [2];
  logic [LEVEL_W-1:0]  fast_level [2];
  logic [LEVEL_W-1:0]  slow_level [2];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_atk_r    <= COEF_BITS'(FAST_ATK_RESET);
      fast_rel_r    <= COEF_BITS'(FAST_REL_RESET);
      slow_atk_r    <= COEF_BITS'(SLOW_ATK_RESET);
      slow_rel_r    <= COEF_BITS'(SLOW_REL_RESET);
      trig_ratio_r  <= TRIG_RATIO_W'(TRIG_RATIO_RESET);
      rearm_ratio_r <= REARM_RATIO_W'(REARM_RATIO_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (ttd_reg_e'(cfg_index))
        REG_FAST_ATK:    fast_atk_r    <= cfg_wdata[COEF_BITS-1:0];
        REG_FAST_REL:    fast_rel_r    <= cfg_wdata[COEF_BITS-1:0];
        REG_SLOW_ATK:    slow_atk_r    <= cfg_wdata[COEF_BITS-1:0];
        REG_SLOW_REL:    slow_rel_r    <= cfg_wdata[COEF_BITS-1:0];
        REG_TRIG_RATIO:  trig_ratio_r  <= cfg_wdata[TRIG_RATIO_W-1:0];
        REG_REARM_RATIO: rearm_ratio_r <= cfg_wdata[REARM_RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_DONE) && out_free);
  assign in_accept = in_valid && in_ready;
  assign fire      = (state_r == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ctrl       = '0;
    ctrl.load  = in_accept;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        ctrl.diff = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ctrl.upd  = 1'b1;
        state_nxt = ST_RATIO;
      end
      ST_RATIO: begin
        ctrl.ratio = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register frees up
        if (out_free) begin
          state_nxt = in_valid ? ST_DIFF : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // lanes
  assign samp[0] = in_left_sample;
  assign samp[1] = in_right_sample;

  for (genvar ch = 0; ch < 2; ch++) begin : g_lane
    if (ch < NUM_CHANNELS) begin : g_on
      ttd_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample      (samp[ch]),
        .fast_atk    (fast_atk_r),
        .fast_rel    (fast_rel_r),
        .slow_atk    (slow_atk_r),
        .slow_rel    (slow_rel_r),
        .trig_ratio  (trig_ratio_r),
        .rearm_ratio (rearm_ratio_r),
        .hit         (hit[ch]),
        .fast_level  (fast_level[ch]),
        .slow_level  (slow_level[ch])
      );
    end else begin : g_off
      assign hit[ch]        = '0;
      assign fast_level[ch] = '0;
      assign slow_level[ch] = '0;
    end
  end

  ttd_merge u_merge (
    .clk                  (clk),
    .rst_n                (rst_n),
    .fire                 (fire),
    .hit                  (hit),
    .fast_level           (fast_level),
    .slow_level           (slow_level),
    .out_ready            (out_ready),
    .out_free             (out_free),
    .out_valid            (out_valid),
    .out_trigger_pulse    (out_trigger_pulse),
    .out_trigger_held     (out_trigger_held),
    .out_left_fast_level  (out_left_fast_level),
    .out_left_slow_level  (out_left_slow_level),
    .out_right_fast_level (out_right_fast_level),
    .out_right_slow_level (out_right_slow_level)
  );

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_DIFF)
    else $error("accepted item did not start the follower sequence");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the final step");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_valid && !out_ready |=> state_r == ST_DONE)
    else $error("final step left while the result register was full");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE && state_r != ST_DONE |-> !in_ready && !fire)
    else $error("item taken or result written mid-sequence");
`endif

endmodule

`default_nettype wire

/* src/ttd_follower.sv */
// ----------------------------------------------------------------------------
// ttd_follower
// One-pole envelope follower with separate attack and release coefficients.
// Difference, multiply and update each take one step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttd_follower #(
  parameter int ENV_W     = 32,
  parameter int COEF_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ttd_pkg::ttd_ctrl_t    ctrl,
  input  wire logic [ENV_W-1:0]      x,
  input  wire logic [COEF_BITS-1:0]  atk_coef,
  input  wire logic [COEF_BITS-1:0]  rel_coef,
  output logic      [ENV_W-1:0]      env
);
  import ttd_pkg::*;

  localparam int PROD_W = ENV_W + COEF_BITS;

  logic [ENV_W-1:0]  env_r, env_nxt;
  logic              up_r;
  logic [ENV_W-1:0]  diff_r;
  logic [PROD_W-1:0] prod_r;
  logic [COEF_BITS-1:0] coef;
  logic [ENV_W-1:0]  step;

  assign coef = up_r ? atk_coef : rel_coef;
  assign step = ENV_W'(prod_r >> COEF_BITS);
  assign env_nxt = up_r ? (x - step) : (x + step);
  assign env = env_r;

  always_ff @(posedge clk) begin
    if (ctrl.diff) begin
      up_r   <= (x > env_r);
      diff_r <= (x > env_r) ? (x - env_r) : (env_r - x);
    end
    if (ctrl.mul) begin
      prod_r <= PROD_W'(coef) * PROD_W'(diff_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (ctrl.upd) begin
      env_r <= env_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ttd_lane.sv */
// ----------------------------------------------------------------------------
// ttd_lane
// Per-channel lane: rectify the sample, run the fast and slow followers,
// floor both envelopes and test them against the trigger and rearm ratios.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttd_lane #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ttd_pkg::ttd_ctrl_t                ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample,
  input  wire logic [COEF_BITS-1:0]              fast_atk,
  input  wire logic [COEF_BITS-1:0]              fast_rel,
  input  wire logic [COEF_BITS-1:0]              slow_atk,
  input  wire logic [COEF_BITS-1:0]              slow_rel,
  input  wire logic [ttd_pkg::TRIG_RATIO_W-1:0]  trig_ratio,
  input  wire logic [ttd_pkg::REARM_RATIO_W-1:0] rearm_ratio,
  output ttd_pkg::ttd_hit_t                      hit,
  output logic [ttd_pkg::LEVEL_W-1:0]            fast_level,
  output logic [ttd_pkg::LEVEL_W-1:0]            slow_level
);
  import ttd_pkg::*;

  localparam int ENV_W  = SAMPLE_BITS + ENV_FRAC;
  localparam int PROD_W = ENV_W + TRIG_RATIO_W;
  // one millionth of full scale
  localparam logic [ENV_W-1:0] ENV_FLOOR =
    ENV_W'((64'd1 << (SAMPLE_BITS + 7)) / 64'd1000000);

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic [ENV_W-1:0]       x_r;
  logic [ENV_W-1:0]       fast_env, slow_env;
  logic [ENV_W-1:0]       f_floor, s_floor;
  logic [ENV_W-1:0]       f_r;
  logic [PROD_W-1:0]      s_trig_r, s_rearm_r;
  logic [PROD_W-1:0]      f_scaled;

  // the most negative sample maps to 2^(SAMPLE_BITS-1) as unsigned
  assign raw = sample;
  assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r <= {mag, {ENV_FRAC{1'b0}}};
    end
  end

  ttd_follower #(.ENV_W(ENV_W), .COEF_BITS(COEF_BITS)) u_fast (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .x        (x_r),
    .atk_coef (fast_atk),
    .rel_coef (fast_rel),
    .env      (fast_env)
  );

  ttd_follower #(.ENV_W(ENV_W), .COEF_BITS(COEF_BITS)) u_slow (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .x        (x_r),
    .atk_coef (slow_atk),
    .rel_coef (slow_rel),
    .env      (slow_env)
  );

  // floor applies to the comparison only
  assign f_floor = (fast_env > ENV_FLOOR) ? fast_env : ENV_FLOOR;
  assign s_floor = (slow_env > ENV_FLOOR) ? slow_env : ENV_FLOOR;

  always_ff @(posedge clk) begin
    if (ctrl.ratio) begin
      f_r       <= f_floor;
      s_trig_r  <= PROD_W'(s_floor) * PROD_W'(trig_ratio);
      s_rearm_r <= PROD_W'(s_floor) * PROD_W'(rearm_ratio);
    end
  end

  assign f_scaled  = PROD_W'({f_r, {RATIO_FRAC{1'b0}}});
  assign hit.trig  = (f_scaled > s_trig_r);
  assign hit.rearm = (f_scaled < s_rearm_r);

  assign fast_level = LEVEL_W'(fast_env >> ENV_FRAC);
  assign slow_level = LEVEL_W'(slow_env >> ENV_FRAC);

endmodule

`default_nettype wire

/* src/ttd_merge.sv */
// ----------------------------------------------------------------------------
// ttd_merge
// Merge the lane flags in channel order into the shared held flag and the
// trigger pulse, and hold the result item until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttd_merge (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fire,
  input  wire ttd_pkg::ttd_hit_t            hit [2],
  input  wire logic [ttd_pkg::LEVEL_W-1:0]  fast_level [2],
  input  wire logic [ttd_pkg::LEVEL_W-1:0]  slow_level [2],
  input  wire logic                         out_ready,
  output logic                              out_free,
  output logic                              out_valid,
  output logic                              out_trigger_pulse,
  output logic                              out_trigger_held,
  output logic [ttd_pkg::LEVEL_W-1:0]       out_left_fast_level,
  output logic [ttd_pkg::LEVEL_W-1:0]       out_left_slow_level,
  output logic [ttd_pkg::LEVEL_W-1:0]       out_right_fast_level,
  output logic [ttd_pkg::LEVEL_W-1:0]       out_right_slow_level
);
  import ttd_pkg::*;

  logic held_r, held_nxt;
  logic pulse_nxt;
  logic out_valid_r, out_valid_nxt;
  logic pulse_r, held_out_r;
  logic [LEVEL_W-1:0] lf_r, ls_r, rf_r, rs_r;

  // left first: the right channel may rearm after the left one fired
  always_comb begin
    held_nxt  = held_r;
    pulse_nxt = 1'b0;
    for (int ch = 0; ch < 2; ch++) begin
      if (hit[ch].trig && !held_nxt) begin
        pulse_nxt = 1'b1;
        held_nxt  = 1'b1;
      end
      if (hit[ch].rearm) begin
        held_nxt = 1'b0;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pulse_r    <= pulse_nxt;
      held_out_r <= held_nxt;
      lf_r       <= fast_level[0];
      ls_r       <= slow_level[0];
      rf_r       <= fast_level[1];
      rs_r       <= slow_level[1];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_trigger_pulse    = pulse_r;
  assign out_trigger_held     = held_out_r;
  assign out_left_fast_level  = lf_r;
  assign out_left_slow_level  = ls_r;
  assign out_right_fast_level = rf_r;
  assign out_right_slow_level = rs_r;

endmodule

`default_nettype wire
